// ===== hw/rtl/ple_pkg.sv =====
// Shared types, codes and constants of the positional list engine.
`timescale 1ns / 1ps

package ple_pkg;

	// Default store depth
	localparam int CAPACITY_DEF = 64;

	// Field widths
	localparam int MODE_W  = 2;
	localparam int POS_W   = 7;
	localparam int VALUE_W = 32;

	// Operation codes
	localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
	localparam logic [MODE_W-1:0] MODE_DELETE = 2'd1;
	localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;

	typedef struct packed {
		logic [MODE_W-1:0]         mode;
		logic [POS_W-1:0]          position;
		logic signed [VALUE_W-1:0] value_in;
	} req_t;

	typedef struct packed {
		logic                      ok;
		logic signed [VALUE_W-1:0] removed_value;
		logic [POS_W-1:0]          found_position;
		logic [POS_W-1:0]          list_length;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_WALK,
		ST_DRAIN,
		ST_PLACE,
		ST_FINISH
	} state_t;

	// Controller to datapath commands
	typedef struct packed {
		logic load;
		logic init;
		logic rd_en;
		logic place;
		logic commit;
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic legal;
		logic no_shift;
		logic last;
		logic is_insert;
	} sts_t;

endpackage

// ===== hw/rtl/ple_stream_if.sv =====
// Valid/ready channel interface carrying one payload per transaction.
`timescale 1ns / 1ps

interface ple_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t payload;

	modport source (output valid, output payload, input ready);
	modport sink (input valid, input payload, output ready);
endinterface

// ===== hw/rtl/ple_ctrl.sv =====
// Controller state machine that sequences one request over the entry store.
`timescale 1ns / 1ps

module ple_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  ple_pkg::sts_t sts,
	output ple_pkg::cmd_t cmd
);

	ple_pkg::state_t state_q;
	ple_pkg::state_t state_nxt;
	logic            out_vld_q;

	// State and output-valid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ple_pkg::ST_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.commit) begin
				out_vld_q <= 1'b1;
			end else if (out_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_vld_q;
	assign in_ready  = (state_q == ple_pkg::ST_IDLE);

	// Next state and commands
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ple_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ple_pkg::ST_CHECK;
				end
			end
			ple_pkg::ST_CHECK: begin
				if (!sts.legal) begin
					state_nxt = ple_pkg::ST_FINISH;
				end else if (sts.is_insert && sts.no_shift) begin
					state_nxt = ple_pkg::ST_PLACE;
				end else begin
					cmd.init  = 1'b1;
					state_nxt = ple_pkg::ST_WALK;
				end
			end
			ple_pkg::ST_WALK: begin
				cmd.rd_en = 1'b1;
				if (sts.last) begin
					state_nxt = ple_pkg::ST_DRAIN;
				end
			end
			ple_pkg::ST_DRAIN: begin
				state_nxt = sts.is_insert ? ple_pkg::ST_PLACE : ple_pkg::ST_FINISH;
			end
			ple_pkg::ST_PLACE: begin
				cmd.place = 1'b1;
				state_nxt = ple_pkg::ST_FINISH;
			end
			ple_pkg::ST_FINISH: begin
				if (!out_vld_q || out_ready) begin
					cmd.commit = 1'b1;
					state_nxt  = ple_pkg::ST_IDLE;
				end
			end
			default: begin
				state_nxt = ple_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/ple_dpath.sv =====
// Datapath: entry store, length count, walk pointer and result register.
`timescale 1ns / 1ps

module ple_dpath #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  ple_pkg::cmd_t cmd,
	output ple_pkg::sts_t sts,
	input  ple_pkg::req_t req_payload,
	output ple_pkg::rsp_t rsp_payload
);

	localparam int CNT_W = $clog2(CAPACITY + 1);
	localparam int IDX_W = $clog2(CAPACITY);
	localparam int EXT_W = ((CNT_W > ple_pkg::POS_W) ? CNT_W : ple_pkg::POS_W) + 1;
	localparam logic [EXT_W-1:0] CAP_EXT = EXT_W'(CAPACITY);
	localparam logic [EXT_W-1:0] ONE     = EXT_W'(1);

	logic signed [ple_pkg::VALUE_W-1:0] mem [CAPACITY];

	logic [ple_pkg::MODE_W-1:0]         mode_q;
	logic [EXT_W-1:0]                   pos_q;
	logic signed [ple_pkg::VALUE_W-1:0] val_q;
	logic [CNT_W-1:0]                   count_q;
	logic [EXT_W-1:0]                   ptr_q;
	logic                               rd_vld_s1;
	logic [EXT_W-1:0]                   idx_s1;
	logic signed [ple_pkg::VALUE_W-1:0] rd_s1;
	logic signed [ple_pkg::VALUE_W-1:0] removed_q;
	logic [ple_pkg::POS_W-1:0]          found_q;
	logic                               hit_q;
	ple_pkg::rsp_t                      out_q;

	logic                               is_ins;
	logic                               is_del;
	logic                               is_srch;
	logic [EXT_W-1:0]                   count_ext;
	logic                               legal;
	logic [EXT_W-1:0]                   end_ext;
	logic [EXT_W-1:0]                   start_ext;
	logic                               wr_en;
	logic [IDX_W-1:0]                   wr_addr;
	logic signed [ple_pkg::VALUE_W-1:0] wr_data;
	logic                               del_head_s1;
	logic                               op_ok;
	logic [CNT_W-1:0]                   count_nxt;

	// Decode the held request
	assign is_ins    = (mode_q == ple_pkg::MODE_INSERT);
	assign is_del    = (mode_q == ple_pkg::MODE_DELETE);
	assign is_srch   = (mode_q == ple_pkg::MODE_SEARCH);
	assign count_ext = EXT_W'(count_q);

	always_comb begin
		legal = 1'b0;
		if (is_ins) begin
			legal = (pos_q != '0) && (pos_q <= count_ext + ONE) && (count_ext < CAP_EXT);
		end else if (is_del) begin
			legal = (pos_q != '0) && (pos_q <= count_ext);
		end else if (is_srch) begin
			legal = (count_ext != '0);
		end
	end

	// Walk bounds: insert runs down from the tail, delete and search run up
	assign end_ext   = is_ins ? (pos_q - ONE) : (count_ext - ONE);
	assign start_ext = is_ins ? (count_ext - ONE) : (is_del ? (pos_q - ONE) : '0);

	assign sts.legal     = legal;
	assign sts.no_shift  = ((pos_q - ONE) == count_ext);
	assign sts.last      = (ptr_q == end_ext);
	assign sts.is_insert = is_ins;

	// Request and pointer registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= req_payload.mode;
			pos_q  <= EXT_W'(req_payload.position);
			val_q  <= req_payload.value_in;
		end
		if (cmd.init) begin
			ptr_q <= start_ext;
		end else if (cmd.rd_en) begin
			ptr_q <= is_ins ? (ptr_q - ONE) : (ptr_q + ONE);
		end
	end

	// Read stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_vld_s1 <= 1'b0;
		end else begin
			rd_vld_s1 <= cmd.rd_en;
		end
	end

	// Store read port, registered
	always_ff @(posedge clk) begin
		if (cmd.rd_en) begin
			rd_s1  <= mem[ptr_q[IDX_W-1:0]];
			idx_s1 <= ptr_q;
		end
	end

	// Write port: shift moves from the read stage, or the insert value
	assign del_head_s1 = (idx_s1 == (pos_q - ONE));

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = '0;
		wr_data = rd_s1;
		if (cmd.place) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(pos_q - ONE);
			wr_data = val_q;
		end else if (rd_vld_s1 && is_ins) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(idx_s1 + ONE);
		end else if (rd_vld_s1 && is_del && !del_head_s1) begin
			wr_en   = 1'b1;
			wr_addr = IDX_W'(idx_s1 - ONE);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	// Capture the removed entry and the first match
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			removed_q <= '0;
			found_q   <= '0;
			hit_q     <= 1'b0;
		end else if (rd_vld_s1) begin
			if (is_del && del_head_s1) begin
				removed_q <= rd_s1;
			end
			if (is_srch && !hit_q && (rd_s1 == val_q)) begin
				hit_q   <= 1'b1;
				found_q <= ple_pkg::POS_W'(idx_s1 + ONE);
			end
		end
	end

	// Result and new length
	assign op_ok = is_srch ? hit_q : legal;

	always_comb begin
		count_nxt = count_q;
		if (legal && is_ins) begin
			count_nxt = count_q + CNT_W'(1);
		end else if (legal && is_del) begin
			count_nxt = count_q - CNT_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.commit) begin
			count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_q.ok             <= op_ok;
			out_q.removed_value  <= (is_del && legal) ? removed_q : '0;
			out_q.found_position <= is_srch ? found_q : '0;
			out_q.list_length    <= ple_pkg::POS_W'(count_nxt);
		end
	end

	assign rsp_payload = out_q;

endmodule

// ===== hw/rtl/positional_list_engine.sv =====
// Top level of the positional list engine: controller plus datapath.
//
// Keeps an ordered list of signed 32-bit values in a store of CAPACITY
// entries. Requests arrive on req (mode, position, value_in); each one
// gives exactly one result on rsp (ok, removed_value, found_position,
// list_length). Both channels are valid/ready; a transaction moves when
// valid and ready are high at a rising clk edge.
// One request is worked at a time. With n entries in the list, insert at
// position p walks n-p+1 entries, delete at p walks n-p+1, search walks n;
// each walked entry is read through the single store read port. Around
// the walk a request passes accept, check, drain and commit, and an insert
// also a place step that writes its value. An insert at the tail skips
// walk and drain; a rejected request goes from check straight to commit.
// The result sits in an output register, so the next request is accepted
// while a result still waits; if rsp stalls, the following request halts
// at commit until the register is free.
// arst_n clears the length to zero and empties both channels; the store
// itself is not cleared, since only written entries are ever read.
`timescale 1ns / 1ps

module positional_list_engine #(
	parameter int CAPACITY = ple_pkg::CAPACITY_DEF
) (
	input logic          clk,
	input logic          arst_n,
	ple_stream_if.sink   req,
	ple_stream_if.source rsp
);

	ple_pkg::cmd_t cmd;
	ple_pkg::sts_t sts;
	ple_pkg::req_t req_payload;
	ple_pkg::rsp_t rsp_payload;

	assign req_payload = req.payload;
	assign rsp.payload = rsp_payload;

	// Sequence each request
	ple_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Store, count and result
	ple_dpath #(
		.CAPACITY (CAPACITY)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req_payload (req_payload),
		.rsp_payload (rsp_payload)
	);

endmodule

// ===== test/tb.sv =====
// Self-checking testbench for the positional list engine: directed table plus random traffic.
`timescale 1ns / 1ps

module tb;
	import ple_pkg::*;

	localparam int LIST_CAPACITY = CAPACITY_DEF;
	localparam int CLK_HALF      = 5;
	localparam int RESET_CYCLES  = 6;
	localparam int RANDOM_ITEMS  = 1300;
	localparam int IDLE_LIMIT    = 4000;
	localparam int HOLD_AT_RESULT = 200;
	localparam int HOLD_CYCLES   = 500;
	localparam int DRAIN_CYCLES  = 2 * LIST_CAPACITY + 20;
	localparam int DIRECTED_N    = 24;

	// Mode code that the block answers without acting on it
	localparam logic [MODE_W-1:0] MODE_UNUSED = 2'd3;

	localparam logic signed [VALUE_W-1:0] VAL_MAX  = 32'sh7FFF_FFFF;
	localparam logic signed [VALUE_W-1:0] VAL_MIN  = 32'sh8000_0000;
	localparam logic signed [VALUE_W-1:0] VAL_NEG1 = -32'sd1;
	localparam logic signed [VALUE_W-1:0] VAL_MID  = 32'sh1234_5678;

	typedef enum logic [1:0] {
		BIAS_FILL,
		BIAS_DRAIN,
		BIAS_MIX
	} bias_t;

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t rsp;
	} vector_t;

	logic clk = 1'b0;
	logic arst_n;

	ple_stream_if #(.payload_t(req_t)) req_ch ();
	ple_stream_if #(.payload_t(rsp_t)) rsp_ch ();

	positional_list_engine #(
		.CAPACITY(LIST_CAPACITY)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always #(CLK_HALF) clk = ~clk;

	// Shadow copy of the list and its length
	logic signed [VALUE_W-1:0] list_model [LIST_CAPACITY];
	int list_len = 0;

	rsp_t expected_rsps [$];
	int error_count = 0;
	int rsp_count = 0;
	bias_t bias = BIAS_FILL;
	logic calm = 1'b0;

	logic signed [VALUE_W-1:0] value_pool [8] = '{
		32'sd0, VAL_NEG1, 32'sd1, VAL_MAX, VAL_MIN, 32'sd42, 32'sh5555_5555, 32'shAAAA_AAAA
	};

	// Directed table; rows with typed set carry their result by hand
	vector_t directed_vectors [DIRECTED_N] = '{
		'{'{MODE_SEARCH, 7'd0,   32'sd0},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
		'{'{MODE_DELETE, 7'd1,   32'sd0},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
		'{'{MODE_INSERT, 7'd0,   32'sd5},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
		'{'{MODE_INSERT, 7'd2,   32'sd5},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd0}},
		'{'{MODE_INSERT, 7'd1,   VAL_MAX}, 1'b1, '{1'b1, 32'sd0, 7'd0, 7'd1}},
		'{'{MODE_INSERT, 7'd1,   VAL_MIN}, 1'b1, '{1'b1, 32'sd0, 7'd0, 7'd2}},
		'{'{MODE_INSERT, 7'd3,   VAL_NEG1}, 1'b1, '{1'b1, 32'sd0, 7'd0, 7'd3}},
		'{'{MODE_INSERT, 7'd2,   VAL_NEG1}, 1'b1, '{1'b1, 32'sd0, 7'd0, 7'd4}},
		'{'{MODE_SEARCH, 7'd127, VAL_NEG1}, 1'b1, '{1'b1, 32'sd0, 7'd2, 7'd4}},
		'{'{MODE_SEARCH, 7'd0,   32'sd0},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
		'{'{MODE_SEARCH, 7'd5,   VAL_MIN}, 1'b1, '{1'b1, 32'sd0, 7'd1, 7'd4}},
		'{'{MODE_UNUSED, 7'd127, VAL_MAX}, 1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
		'{'{MODE_INSERT, 7'd127, 32'sd0},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
		'{'{MODE_INSERT, 7'd6,   32'sd0},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
		'{'{MODE_DELETE, 7'd5,   32'sd0},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
		'{'{MODE_DELETE, 7'd0,   32'sd0},  1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
		'{'{MODE_DELETE, 7'd127, VAL_MIN}, 1'b1, '{1'b0, 32'sd0, 7'd0, 7'd4}},
		'{'{MODE_DELETE, 7'd3,   32'sd0},  1'b1, '{1'b1, VAL_MAX, 7'd0, 7'd3}},
		'{'{MODE_DELETE, 7'd1,   32'sd0},  1'b1, '{1'b1, VAL_MIN, 7'd0, 7'd2}},
		'{'{MODE_INSERT, 7'd3,   VAL_MID}, 1'b0, '0},
		'{'{MODE_SEARCH, 7'd0,   VAL_NEG1}, 1'b0, '0},
		'{'{MODE_DELETE, 7'd3,   32'sd0},  1'b0, '0},
		'{'{MODE_DELETE, 7'd1,   32'sd0},  1'b1, '{1'b1, VAL_NEG1, 7'd0, 7'd1}},
		'{'{MODE_DELETE, 7'd1,   32'sd0},  1'b1, '{1'b1, VAL_NEG1, 7'd0, 7'd0}}
	};

	// Apply one request to the shadow list and return the result it gives
	function automatic rsp_t apply_request(input req_t r);
		rsp_t res;
		int pos;
		int i;
		bit hit;
		res = '0;
		pos = r.position;
		hit = 1'b0;
		case (r.mode)
			MODE_INSERT: begin
				if (pos >= 1 && pos <= list_len + 1 && list_len < LIST_CAPACITY) begin
					for (i = list_len; i >= pos; i--)
						list_model[i] = list_model[i-1];
					list_model[pos-1] = r.value_in;
					list_len++;
					res.ok = 1'b1;
				end
			end
			MODE_DELETE: begin
				if (pos >= 1 && pos <= list_len) begin
					res.removed_value = list_model[pos-1];
					for (i = pos; i < list_len; i++)
						list_model[i-1] = list_model[i];
					list_len--;
					res.ok = 1'b1;
				end
			end
			MODE_SEARCH: begin
				for (i = 0; i < list_len && !hit; i++) begin
					if (list_model[i] == r.value_in) begin
						res.found_position = POS_W'(i + 1);
						res.ok = 1'b1;
						hit = 1'b1;
					end
				end
			end
			default: begin
			end
		endcase
		res.list_length = POS_W'(list_len);
		return res;
	endfunction

	// Mostly short gaps, a few long ones, none while calm
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (calm)
			return 0;
		if (roll < 55)
			return 0;
		if (roll < 88)
			return $urandom_range(1, 3);
		if (roll < 98)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	// Draw a request, mostly legal positions, weighted by the current bias
	function automatic req_t next_request();
		req_t r;
		int roll;
		int ins_w;
		int del_w;
		case (bias)
			BIAS_FILL: begin
				ins_w = 65;
				del_w = 10;
			end
			BIAS_DRAIN: begin
				ins_w = 10;
				del_w = 65;
			end
			default: begin
				ins_w = 35;
				del_w = 30;
			end
		endcase
		roll = $urandom_range(0, 99);
		if (roll < ins_w)
			r.mode = MODE_INSERT;
		else if (roll < ins_w + del_w)
			r.mode = MODE_DELETE;
		else if (roll < 96)
			r.mode = MODE_SEARCH;
		else
			r.mode = MODE_UNUSED;

		if ($urandom_range(0, 99) < 15 || r.mode == MODE_SEARCH)
			r.position = POS_W'($urandom_range(0, 127));
		else if (r.mode == MODE_INSERT)
			r.position = POS_W'($urandom_range(1, list_len + 1));
		else
			r.position = POS_W'($urandom_range(1, (list_len > 0) ? list_len : 1));

		roll = $urandom_range(0, 99);
		if (r.mode == MODE_SEARCH && list_len > 0 && roll < 50)
			r.value_in = list_model[$urandom_range(0, list_len - 1)];
		else if (roll < 80 && roll >= 50)
			r.value_in = value_pool[$urandom_range(0, 7)];
		else
			r.value_in = $urandom;
		return r;
	endfunction

	task automatic report_mismatch(input string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		error_count++;
	endtask

	// Compare one result against the oldest expectation
	task automatic check_result(input rsp_t got);
		rsp_t want;
		rsp_count++;
		if (expected_rsps.size() == 0) begin
			report_mismatch($sformatf("result %0d arrived with nothing expected", rsp_count));
			return;
		end
		want = expected_rsps.pop_front();
		if (got.ok !== want.ok)
			report_mismatch($sformatf("result %0d ok: got %0b want %0b",
				rsp_count, got.ok, want.ok));
		if (got.removed_value !== want.removed_value)
			report_mismatch($sformatf("result %0d removed_value: got %0d want %0d",
				rsp_count, got.removed_value, want.removed_value));
		if (got.found_position !== want.found_position)
			report_mismatch($sformatf("result %0d found_position: got %0d want %0d",
				rsp_count, got.found_position, want.found_position));
		if (got.list_length !== want.list_length)
			report_mismatch($sformatf("result %0d list_length: got %0d want %0d",
				rsp_count, got.list_length, want.list_length));
	endtask

	// Offer one request, hold it until accepted, then record what it should give
	task automatic send_request(input req_t r, input bit typed, input rsp_t typed_rsp);
		int gap;
		rsp_t predicted;
		gap = pick_gap();
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid   <= 1'b1;
		req_ch.payload <= r;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		predicted = apply_request(r);
		expected_rsps.push_back(typed ? typed_rsp : predicted);
	endtask

	// Switch between calm stretches and stretches with idling
	initial begin
		forever begin
			repeat ($urandom_range(50, 400)) @(posedge clk);
			calm <= ($urandom_range(0, 3) == 0);
		end
	end

	// Result side: check each transaction, stall at random, hold off once for long
	initial begin
		int hold_left;
		bit hold_done;
		int gap;
		hold_left = 0;
		hold_done = 1'b0;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rsp_ch.valid && rsp_ch.ready)
				check_result(rsp_ch.payload);
			if (hold_left > 0) begin
				hold_left--;
				rsp_ch.ready <= 1'b0;
			end else if (!hold_done && rsp_count >= HOLD_AT_RESULT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				rsp_ch.ready <= 1'b0;
			end else begin
				gap = ($urandom_range(0, 2) == 0) ? pick_gap() : 0;
				if (gap > 0) begin
					hold_left = gap - 1;
					rsp_ch.ready <= 1'b0;
				end else begin
					rsp_ch.ready <= 1'b1;
				end
			end
		end
	end

	// Watchdog: end the run when no transaction moves for too long
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < IDLE_LIMIT) begin
			@(posedge clk);
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("TB_ERROR");
		$finish;
	end

	// Request side: reset, directed table, random traffic, drain
	initial begin
		arst_n = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.payload = '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;

		foreach (directed_vectors[k])
			send_request(directed_vectors[k].req, directed_vectors[k].typed,
				directed_vectors[k].rsp);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			send_request(next_request(), 1'b0, '0);
			// advance the bias: fill to full, drain to empty, mix in between
			if (bias == BIAS_FILL && list_len == LIST_CAPACITY && $urandom_range(0, 3) == 0)
				bias = BIAS_DRAIN;
			else if (bias == BIAS_DRAIN && list_len == 0)
				bias = ($urandom_range(0, 2) == 0) ? BIAS_MIX : BIAS_FILL;
			else if (bias == BIAS_MIX && $urandom_range(0, 59) == 0)
				bias = BIAS_FILL;
		end
		req_ch.valid <= 1'b0;

		while (expected_rsps.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
